/* src/jdm_pkg.sv */
// Shared types, widths and constants for the joystick deadzone mirror drive.
`timescale 1ns / 1ps
package jdm_pkg;

  // Serial multiplier: signed multiplicand, unsigned multiplier, one bit per cycle.
  localparam int unsigned MulAW = 26;
  localparam int unsigned MulBW = 25;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Serial restoring divider: unsigned, one quotient bit per cycle.
  localparam int unsigned DivNW = 40;
  localparam int unsigned DivDW = 16;

  // Working values are signed Q1.15 with headroom, saturated to +-(2^23 - 1).
  localparam int unsigned WorkW = 24;

  typedef logic signed [WorkW-1:0] work_t;
  typedef logic signed [MulPW-1:0] prod_t;

  localparam work_t SatLim = work_t'(8388607);
  localparam prod_t SatHi  = prod_t'(8388607);
  localparam prod_t SatLo  = prod_t'(-8388607);
  localparam logic [DivNW-1:0] SatMag = DivNW'(8388607);
  localparam logic [MulBW-1:0] FacCap = MulBW'(16777216);

  localparam logic [15:0] KeepQ16  = 16'd45875;
  localparam logic [15:0] AlphaQ16 = 16'd19661;

  localparam prod_t GainRnd  = prod_t'(2048);
  localparam prod_t SmoothRnd = prod_t'(32768);
  localparam prod_t MvRnd    = prod_t'(16384);

  typedef enum logic [2:0] {
    CfgXSel, CfgYSel, CfgInvX, CfgInvY, CfgXGain, CfgYGain, CfgRadius, CfgRange
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RangeBi10, RangeBi5, RangeUni10, RangeSpare
  } range_e;

  typedef enum logic [4:0] {
    StIdle, StSqX, StSqY, StSqrt, StChk, StFac, StMulX, StDivX, StMulY, StDivY,
    StInv, StGainX, StGainY, StKeepX, StAlphaX, StKeepY, StAlphaY, StMvX, StMvY,
    StOut
  } state_e;

endpackage

/* src/jdm_mul.sv */
// Bit-serial signed by unsigned multiplier, accumulator shifts right one bit per cycle.
`timescale 1ns / 1ps
module jdm_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [jdm_pkg::MulAW-1:0]     a_i,
  input  logic        [jdm_pkg::MulBW-1:0]     b_i,
  output logic                                 done_o,
  output jdm_pkg::prod_t                       p_o
);

  localparam int unsigned CntW = $clog2(jdm_pkg::MulBW + 1);

  logic signed [jdm_pkg::MulAW-1:0] a_q, a_d;
  logic        [jdm_pkg::MulBW-1:0] b_q, b_d;
  logic        [jdm_pkg::MulPW-1:0] p_q, p_d;
  logic        [CntW-1:0]           cnt_q, cnt_d;
  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic signed [jdm_pkg::MulAW:0]   hi_ext, a_ext, hi_sum;

  always_comb begin
    hi_ext = {p_q[jdm_pkg::MulPW-1], p_q[jdm_pkg::MulPW-1:jdm_pkg::MulBW]};
    a_ext  = {a_q[jdm_pkg::MulAW-1], a_q};
    hi_sum = b_q[0] ? (hi_ext + a_ext) : hi_ext;
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      p_d    = '0;
      cnt_d  = CntW'(jdm_pkg::MulBW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      p_d   = {hi_sum, p_q[jdm_pkg::MulBW-1:1]};
      b_d   = b_q >> 1;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign done_o = done_q;
  assign p_o    = signed'(p_q);

endmodule

/* src/jdm_div.sv */
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module jdm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [jdm_pkg::DivNW-1:0]    n_i,
  input  logic [jdm_pkg::DivDW-1:0]    d_i,
  output logic                         done_o,
  output logic [jdm_pkg::DivNW-1:0]    q_o
);

  localparam int unsigned CntW = $clog2(jdm_pkg::DivNW + 1);

  logic [jdm_pkg::DivNW-1:0] n_q, n_d;
  logic [jdm_pkg::DivDW-1:0] d_q, d_d;
  logic [jdm_pkg::DivDW-1:0] r_q, r_d;
  logic [jdm_pkg::DivDW:0]   trial, diff;
  logic                      ge;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;

  always_comb begin
    trial  = {r_q, n_q[jdm_pkg::DivNW-1]};
    diff   = trial - {1'b0, d_q};
    ge     = (trial >= {1'b0, d_q});
    n_d    = n_q;
    d_d    = d_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      n_d    = n_i;
      d_d    = d_i;
      r_d    = '0;
      cnt_d  = CntW'(jdm_pkg::DivNW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = ge ? diff[jdm_pkg::DivDW-1:0] : trial[jdm_pkg::DivDW-1:0];
      n_d   = {n_q[jdm_pkg::DivNW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    d_q <= d_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign q_o    = n_q;

endmodule

/* src/joystick_deadzone_mirror_drive_unit.sv */
// Top level: joystick radial deadzone, gain, smoothing and millivolt drive sequencer.
`timescale 1ns / 1ps
// An axis event (func 0) is accepted whenever the unit is idle and only updates the latched X or Y
// reading. A tick (func 1) runs a sequencer over one bit-serial multiplier and one bit-serial
// divider plus a 16-step square root; a tick in the deadzone skips the rescale products and
// quotients. Input is stalled while a tick is in progress; the result sits in an output
// register, and a following tick waits at its end only if that register is still full.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i; the user must write
// it only while idle, which the block itself does not enforce.
module joystick_deadzone_mirror_drive_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic        [7:0]  axis_number_i,
  input  logic signed [15:0] axis_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] x_millivolts_o,
  output logic signed [14:0] y_millivolts_o,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_index_i,
  input  logic        [15:0] cfg_data_i
);

  // configuration
  logic [7:0]       xsel_q, ysel_q;
  logic             invx_q, invy_q;
  logic [15:0]      xgain_q, ygain_q, radius_q;
  jdm_pkg::range_e  range_q;

  // state and datapath
  jdm_pkg::state_e  state_q, state_d;
  logic             launched_q, launched_d;
  logic signed [15:0] xlat_q, xlat_d, ylat_q, ylat_d;
  jdm_pkg::work_t   wx_q, wx_d, wy_q, wy_d;
  jdm_pkg::work_t   sx_q, sx_d, sy_q, sy_d;
  jdm_pkg::work_t   mag;
  jdm_pkg::prod_t   acc_q, acc_d, rnd;
  logic [31:0]      d2_q, d2_d;
  logic [17:0]      rem_q, rem_d;
  logic [19:0]      rem_t, sq_trial;
  logic [15:0]      root_q, root_d;
  logic [3:0]       sq_cnt_q, sq_cnt_d;
  logic [jdm_pkg::MulBW-1:0] fac_q, fac_d;
  logic signed [14:0] mvx_q, mvx_d, mvy_q, mvy_d;
  logic signed [14:0] xo_q, xo_d, yo_q, yo_d;
  logic             ovalid_q, ovalid_d;
  logic signed [15:0] raw_clamped;
  logic [13:0]      mv_mid, mv_half;

  // shared units
  logic                             mul_start, mul_done;
  logic signed [jdm_pkg::MulAW-1:0] mul_a;
  logic        [jdm_pkg::MulBW-1:0] mul_b;
  jdm_pkg::prod_t                   mul_p;
  logic                             div_start, div_done;
  logic [jdm_pkg::DivNW-1:0]        div_n, div_q;
  logic [jdm_pkg::DivDW-1:0]        div_d;

  function automatic jdm_pkg::work_t norm_raw(logic signed [15:0] r);
    jdm_pkg::work_t v;
    v = jdm_pkg::WorkW'(r);
    if (r >= 16'sd16384) v = v + jdm_pkg::work_t'(1);
    if (r <= -16'sd16384) v = v - jdm_pkg::work_t'(1);
    return v;
  endfunction

  function automatic logic [jdm_pkg::MulBW-1:0] abs_w(jdm_pkg::work_t v);
    logic signed [jdm_pkg::WorkW:0] e;
    e = {v[jdm_pkg::WorkW-1], v};
    if (v < 0) e = -e;
    return jdm_pkg::MulBW'(e);
  endfunction

  function automatic jdm_pkg::work_t sat_w(jdm_pkg::prod_t v);
    jdm_pkg::work_t r;
    r = v[jdm_pkg::WorkW-1:0];
    if (v > jdm_pkg::SatHi) r = jdm_pkg::SatLim;
    if (v < jdm_pkg::SatLo) r = -jdm_pkg::SatLim;
    return r;
  endfunction

  function automatic logic signed [14:0] clamp_mv(jdm_pkg::prod_t p, logic [13:0] mid,
                                                  logic [13:0] half);
    jdm_pkg::prod_t r;
    logic signed [26:0] v, lo, hi;
    r  = (p + jdm_pkg::MvRnd) >>> 15;
    lo = signed'({13'b0, mid}) - signed'({13'b0, half});
    hi = signed'({13'b0, mid}) + signed'({13'b0, half});
    v  = signed'(r[26:0]) + signed'({13'b0, mid});
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v[14:0];
  endfunction

  jdm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  jdm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xsel_q   <= 8'd0;
      ysel_q   <= 8'd1;
      invx_q   <= 1'b0;
      invy_q   <= 1'b0;
      xgain_q  <= 16'd4096;
      ygain_q  <= 16'd4096;
      radius_q <= 16'd1638;
      range_q  <= jdm_pkg::RangeBi10;
    end else if (cfg_we_i) begin
      unique case (jdm_pkg::cfg_idx_e'(cfg_index_i))
        jdm_pkg::CfgXSel:   xsel_q   <= cfg_data_i[7:0];
        jdm_pkg::CfgYSel:   ysel_q   <= cfg_data_i[7:0];
        jdm_pkg::CfgInvX:   invx_q   <= cfg_data_i[0];
        jdm_pkg::CfgInvY:   invy_q   <= cfg_data_i[0];
        jdm_pkg::CfgXGain:  xgain_q  <= cfg_data_i;
        jdm_pkg::CfgYGain:  ygain_q  <= cfg_data_i;
        jdm_pkg::CfgRadius: radius_q <= cfg_data_i;
        jdm_pkg::CfgRange:  range_q  <= jdm_pkg::range_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (range_q)
      jdm_pkg::RangeBi5: begin
        mv_mid  = 14'd0;
        mv_half = 14'd5000;
      end
      jdm_pkg::RangeUni10: begin
        mv_mid  = 14'd5000;
        mv_half = 14'd5000;
      end
      default: begin
        mv_mid  = 14'd0;
        mv_half = 14'd10000;
      end
    endcase
  end

  assign raw_clamped = (axis_value_i == -16'sd32768) ? -16'sd32767 : axis_value_i;
  assign in_stall_o  = (state_q != jdm_pkg::StIdle);

  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    xlat_d     = xlat_q;
    ylat_d     = ylat_q;
    wx_d       = wx_q;
    wy_d       = wy_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    acc_d      = acc_q;
    d2_d       = d2_q;
    rem_d      = rem_q;
    root_d     = root_q;
    sq_cnt_d   = sq_cnt_q;
    fac_d      = fac_q;
    mvx_d      = mvx_q;
    mvy_d      = mvy_q;
    xo_d       = xo_q;
    yo_d       = yo_q;
    ovalid_d   = ovalid_q;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_n      = '0;
    div_d      = '0;
    mag        = '0;
    rnd        = '0;
    rem_t      = {rem_q, d2_q[31:30]};
    sq_trial   = {2'b00, root_q, 2'b01};

    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;

    unique case (state_q)
      jdm_pkg::StIdle: begin
        if (in_valid_i) begin
          if (!func_i) begin
            if (axis_number_i == xsel_q) xlat_d = raw_clamped;
            if (axis_number_i == ysel_q) ylat_d = raw_clamped;
          end else begin
            wx_d    = norm_raw(xlat_q);
            wy_d    = norm_raw(ylat_q);
            state_d = jdm_pkg::StSqX;
          end
        end
      end
      jdm_pkg::StSqX, jdm_pkg::StSqY: begin
        mul_a = signed'({1'b0, (state_q == jdm_pkg::StSqX) ? abs_w(wx_q) : abs_w(wy_q)});
        mul_b = (state_q == jdm_pkg::StSqX) ? abs_w(wx_q) : abs_w(wy_q);
        mul_start = !launched_q;
        launched_d = 1'b1;
        if (mul_done) begin
          launched_d = 1'b0;
          if (state_q == jdm_pkg::StSqX) begin
            d2_d    = mul_p[31:0];
            state_d = jdm_pkg::StSqY;
          end else begin
            d2_d     = d2_q + mul_p[31:0];
            rem_d    = '0;
            root_d   = '0;
            sq_cnt_d = '0;
            state_d  = jdm_pkg::StSqrt;
          end
        end
      end
      jdm_pkg::StSqrt: begin
        // one result bit per step, two radicand bits shifted in
        if (rem_t >= sq_trial) begin
          rem_d  = 18'(rem_t - sq_trial);
          root_d = {root_q[14:0], 1'b1};
        end else begin
          rem_d  = rem_t[17:0];
          root_d = {root_q[14:0], 1'b0};
        end
        d2_d     = {d2_q[29:0], 2'b00};
        sq_cnt_d = sq_cnt_q + 4'd1;
        if (sq_cnt_q == 4'd15) state_d = jdm_pkg::StChk;
      end
      jdm_pkg::StChk: begin
        // zero distance, radius of one or more, or inside the deadzone
        if (root_q == 16'd0 || radius_q[15] || root_q < radius_q) begin
          wx_d    = '0;
          wy_d    = '0;
          state_d = jdm_pkg::StInv;
        end else begin
          state_d = jdm_pkg::StFac;
        end
      end
      jdm_pkg::StFac: begin
        div_n = jdm_pkg::DivNW'({16'(root_q - radius_q), 15'b0});
        div_d = 16'(17'h08000 - {1'b0, radius_q});
        div_start  = !launched_q;
        launched_d = 1'b1;
        if (div_done) begin
          launched_d = 1'b0;
          fac_d = (div_q > jdm_pkg::DivNW'(jdm_pkg::FacCap)) ? jdm_pkg::FacCap
                                                           : div_q[jdm_pkg::MulBW-1:0];
          state_d = jdm_pkg::StMulX;
        end
      end
      jdm_pkg::StMulX, jdm_pkg::StMulY: begin
        mul_a = signed'({1'b0, (state_q == jdm_pkg::StMulX) ? abs_w(wx_q) : abs_w(wy_q)});
        mul_b = fac_q;
        mul_start  = !launched_q;
        launched_d = 1'b1;
        if (mul_done) begin
          launched_d = 1'b0;
          acc_d      = mul_p;
          state_d    = (state_q == jdm_pkg::StMulX) ? jdm_pkg::StDivX : jdm_pkg::StDivY;
        end
      end
      jdm_pkg::StDivX, jdm_pkg::StDivY: begin
        div_n = acc_q[jdm_pkg::DivNW-1:0];
        div_d = root_q;
        div_start  = !launched_q;
        launched_d = 1'b1;
        if (div_done) begin
          launched_d = 1'b0;
          mag = (div_q > jdm_pkg::SatMag) ? jdm_pkg::SatLim
                                          : signed'(div_q[jdm_pkg::WorkW-1:0]);
          if (state_q == jdm_pkg::StDivX) begin
            wx_d    = wx_q[jdm_pkg::WorkW-1] ? -mag : mag;
            state_d = jdm_pkg::StMulY;
          end else begin
            wy_d    = wy_q[jdm_pkg::WorkW-1] ? -mag : mag;
            state_d = jdm_pkg::StInv;
          end
        end
      end
      jdm_pkg::StInv: begin
        if (invx_q) wx_d = -wx_q;
        if (invy_q) wy_d = -wy_q;
        state_d = jdm_pkg::StGainX;
      end
      jdm_pkg::StGainX, jdm_pkg::StGainY: begin
        mul_a = jdm_pkg::MulAW'((state_q == jdm_pkg::StGainX) ? wx_q : wy_q);
        mul_b = jdm_pkg::MulBW'((state_q == jdm_pkg::StGainX) ? xgain_q : ygain_q);
        mul_start  = !launched_q;
        launched_d = 1'b1;
        if (mul_done) begin
          launched_d = 1'b0;
          rnd = (mul_p + jdm_pkg::GainRnd) >>> 12;
          if (state_q == jdm_pkg::StGainX) begin
            wx_d    = sat_w(rnd);
            state_d = jdm_pkg::StGainY;
          end else begin
            wy_d    = sat_w(rnd);
            state_d = jdm_pkg::StKeepX;
          end
        end
      end
      jdm_pkg::StKeepX, jdm_pkg::StKeepY: begin
        mul_a = jdm_pkg::MulAW'((state_q == jdm_pkg::StKeepX) ? sx_q : sy_q);
        mul_b = jdm_pkg::MulBW'(jdm_pkg::KeepQ16);
        mul_start  = !launched_q;
        launched_d = 1'b1;
        if (mul_done) begin
          launched_d = 1'b0;
          acc_d      = mul_p;
          state_d = (state_q == jdm_pkg::StKeepX) ? jdm_pkg::StAlphaX : jdm_pkg::StAlphaY;
        end
      end
      jdm_pkg::StAlphaX, jdm_pkg::StAlphaY: begin
        mul_a = jdm_pkg::MulAW'((state_q == jdm_pkg::StAlphaX) ? wx_q : wy_q);
        mul_b = jdm_pkg::MulBW'(jdm_pkg::AlphaQ16);
        mul_start  = !launched_q;
        launched_d = 1'b1;
        if (mul_done) begin
          launched_d = 1'b0;
          rnd = (acc_q + mul_p + jdm_pkg::SmoothRnd) >>> 16;
          if (state_q == jdm_pkg::StAlphaX) begin
            sx_d    = sat_w(rnd);
            state_d = jdm_pkg::StKeepY;
          end else begin
            sy_d    = sat_w(rnd);
            state_d = jdm_pkg::StMvX;
          end
        end
      end
      jdm_pkg::StMvX, jdm_pkg::StMvY: begin
        mul_a = jdm_pkg::MulAW'((state_q == jdm_pkg::StMvX) ? sx_q : sy_q);
        mul_b = jdm_pkg::MulBW'(mv_half);
        mul_start  = !launched_q;
        launched_d = 1'b1;
        if (mul_done) begin
          launched_d = 1'b0;
          if (state_q == jdm_pkg::StMvX) begin
            mvx_d   = clamp_mv(mul_p, mv_mid, mv_half);
            state_d = jdm_pkg::StMvY;
          end else begin
            mvy_d   = clamp_mv(mul_p, mv_mid, mv_half);
            state_d = jdm_pkg::StOut;
          end
        end
      end
      jdm_pkg::StOut: begin
        if (!ovalid_q || !out_stall_i) begin
          xo_d     = mvx_q;
          yo_d     = mvy_q;
          ovalid_d = 1'b1;
          state_d  = jdm_pkg::StIdle;
        end
      end
      default: state_d = jdm_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= jdm_pkg::StIdle;
      launched_q <= 1'b0;
      ovalid_q   <= 1'b0;
      xlat_q     <= '0;
      ylat_q     <= '0;
      sx_q       <= '0;
      sy_q       <= '0;
      sq_cnt_q   <= '0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      ovalid_q   <= ovalid_d;
      xlat_q     <= xlat_d;
      ylat_q     <= ylat_d;
      sx_q       <= sx_d;
      sy_q       <= sy_d;
      sq_cnt_q   <= sq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wx_q   <= wx_d;
    wy_q   <= wy_d;
    acc_q  <= acc_d;
    d2_q   <= d2_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    fac_q  <= fac_d;
    mvx_q  <= mvx_d;
    mvy_q  <= mvy_d;
    xo_q   <= xo_d;
    yo_q   <= yo_d;
  end

  assign out_valid_o    = ovalid_q;
  assign x_millivolts_o = xo_q;
  assign y_millivolts_o = yo_q;

endmodule

/* verif/tb.sv */
// Self-checking testbench for the joystick deadzone mirror drive unit.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned SettleCycles = 600;  // a full tick plus margin
  localparam int unsigned HoldCycles = 2500;

  typedef struct packed {
    logic signed [14:0] x_mv;
    logic signed [14:0] y_mv;
  } drive_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = 1'b0;
  logic [7:0] axis_number = '0;
  logic signed [15:0] axis_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [14:0] x_mv_o, y_mv_o;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  joystick_deadzone_mirror_drive_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .axis_number_i(axis_number), .axis_value_i(axis_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .x_millivolts_o(x_mv_o), .y_millivolts_o(y_mv_o),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------- drive predictor ----------------
  longint sel_x, sel_y, inv_x, inv_y, gain_x, gain_y, radius, span;
  longint raw_x, raw_y, filt_x, filt_y;
  drive_t drive_q[$];

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic hold_req = 1'b0;

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint round_div(longint n, longint d);
    return floor_div(2 * n + d, 2 * d);
  endfunction

  function automatic longint clip_work(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388607) return -8388607;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint stretch(longint v, longint fac, longint d);
    longint m, r;
    m = v < 0 ? -v : v;
    r = (m * fac) / d;
    return clip_work(v < 0 ? -r : r);
  endfunction

  function automatic longint to_millivolts(longint s);
    longint mid, half, mv;
    mid = 0;
    half = 10000;
    if (span == jdm_pkg::RangeBi5) half = 5000;
    else if (span == jdm_pkg::RangeUni10) begin
      mid = 5000;
      half = 5000;
    end
    mv = mid + round_div(s * half, 32768);
    if (mv < mid - half) mv = mid - half;
    if (mv > mid + half) mv = mid + half;
    return mv;
  endfunction

  function automatic void set_reg(jdm_pkg::cfg_idx_e idx, longint v);
    case (idx)
      jdm_pkg::CfgXSel: sel_x = v & 8'hFF;
      jdm_pkg::CfgYSel: sel_y = v & 8'hFF;
      jdm_pkg::CfgInvX: inv_x = v & 1;
      jdm_pkg::CfgInvY: inv_y = v & 1;
      jdm_pkg::CfgXGain: gain_x = v & 16'hFFFF;
      jdm_pkg::CfgYGain: gain_y = v & 16'hFFFF;
      jdm_pkg::CfgRadius: radius = v & 16'hFFFF;
      jdm_pkg::CfgRange: span = v & 3;
      default: ;
    endcase
  endfunction

  // Returns 1 and the expected drive when the transaction is a tick.
  function automatic bit predict_drive(logic f, logic [7:0] num, logic signed [15:0] val,
                                       output drive_t res);
    longint x, y, d2, d, fac, r;
    res = '0;
    if (!f) begin
      r = val;
      if (r < -32767) r = -32767;
      if (num == sel_x) raw_x = r;
      if (num == sel_y) raw_y = r;
      return 1'b0;
    end
    x = round_div(raw_x * 32768, 32767);
    y = round_div(raw_y * 32768, 32767);
    d2 = x * x + y * y;
    d = int_sqrt(d2);
    if (d2 == 0 || radius >= 32768 || d < radius) begin
      x = 0;
      y = 0;
    end else begin
      fac = ((d - radius) << 15) / (32768 - radius);
      if (fac > 16777216) fac = 16777216;
      x = stretch(x, fac, d);
      y = stretch(y, fac, d);
    end
    if (inv_x != 0) x = -x;
    if (inv_y != 0) y = -y;
    x = clip_work(round_div(x * gain_x, 4096));
    y = clip_work(round_div(y * gain_y, 4096));
    filt_x = clip_work(round_div(filt_x * 45875 + x * 19661, 65536));
    filt_y = clip_work(round_div(filt_y * 45875 + y * 19661, 65536));
    res.x_mv = 15'(to_millivolts(filt_x));
    res.y_mv = 15'(to_millivolts(filt_y));
    return 1'b1;
  endfunction

  // ---------------- result checker and receiver ----------------
  always @(negedge clk) begin
    drive_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected drive result x=%0d y=%0d", x_mv_o, y_mv_o);
      end else begin
        want = drive_q.pop_front();
        if (want.x_mv !== x_mv_o || want.y_mv !== y_mv_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("drive mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                     want.x_mv, want.y_mv, x_mv_o, y_mv_o);
        end
      end
    end
  end

  logic hold_seen = 1'b0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------- sender side ----------------
  task automatic send_item(logic f, logic [7:0] num, logic signed [15:0] val);
    bit taken;
    drive_t res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    axis_number <= num;
    axis_value <= val;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (predict_drive(f, num, val, res)) drive_q.push_back(res);
  endtask

  // Sender stays quiet until every pending result is out and the unit is idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(jdm_pkg::cfg_idx_e idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    set_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic tick();
    send_item(1'b1, 8'($urandom), 16'($urandom));
  endtask

  task automatic stick(logic signed [15:0] xv, logic signed [15:0] yv);
    send_item(1'b0, 8'(sel_x), xv);
    send_item(1'b0, 8'(sel_y), yv);
  endtask

  task automatic random_config();
    write_reg(jdm_pkg::CfgXSel, 16'($urandom_range(3)));
    write_reg(jdm_pkg::CfgYSel, 16'($urandom_range(3)));
    write_reg(jdm_pkg::CfgInvX, 16'($urandom_range(1)));
    write_reg(jdm_pkg::CfgInvY, 16'($urandom_range(1)));
    write_reg(jdm_pkg::CfgXGain,
              ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(8192)));
    write_reg(jdm_pkg::CfgYGain, ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom));
    write_reg(jdm_pkg::CfgRadius, ($urandom_range(9) == 0) ? 16'($urandom) :
                                  16'($urandom_range(6000)));
    write_reg(jdm_pkg::CfgRange, 16'($urandom_range(3)));
  endtask

  task automatic random_item();
    logic signed [15:0] v;
    int pick;
    pick = $urandom_range(99);
    case ($urandom_range(5))
      0: v = 16'sh8000;
      1: v = 16'sh7FFF;
      2: v = 16'($signed(16'($urandom_range(2000))) - 16'sd1000);
      default: v = 16'($urandom);
    endcase
    if (pick < 40) tick();
    else if (pick < 65) send_item(1'b0, 8'(sel_x), v);
    else if (pick < 90) send_item(1'b0, 8'(sel_y), v);
    else send_item(1'b0, 8'($urandom), v);
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    tick();                                 // zero distance after reset
    stick(16'sh7FFF, 16'sh8000);            // full scale, most negative raw
    tick();
    send_item(1'b0, 8'd200, 16'sh1234);     // unmatched axis
    tick();
    stick(16'sd500, -16'sd300);             // inside the deadzone
    tick();
    drain();
    write_reg(jdm_pkg::CfgYSel, 16'd0);     // one axis drives both
    write_reg(jdm_pkg::CfgInvX, 16'd1);
    write_reg(jdm_pkg::CfgInvY, 16'd1);
    write_reg(jdm_pkg::CfgXGain, 16'hFFFF);
    write_reg(jdm_pkg::CfgYGain, 16'd0);
    write_reg(jdm_pkg::CfgRange, jdm_pkg::RangeUni10);
    send_item(1'b0, 8'd0, -16'sd20000);
    tick();
    tick();
    drain();
    write_reg(jdm_pkg::CfgRadius, 16'd32767);   // huge rescale factor
    write_reg(jdm_pkg::CfgRange, jdm_pkg::RangeSpare);
    write_reg(jdm_pkg::CfgXSel, 16'd255);
    send_item(1'b0, 8'd255, 16'sh7FFF);
    tick();
    drain();
    write_reg(jdm_pkg::CfgRadius, 16'd32768);   // radius of one
    write_reg(jdm_pkg::CfgRange, jdm_pkg::RangeBi5);
    tick();
    drain();
    write_reg(jdm_pkg::CfgRadius, 16'hFFFF);
    write_reg(jdm_pkg::CfgRange, jdm_pkg::RangeBi10);
    tick();
    drain();
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    random_config();
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    repeat (n) random_item();
    drain();
  endtask

  task automatic test_backpressure();
    random_config();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_req <= ~hold_req;
    stick(16'sd30000, -16'sd12000);
    repeat (4) tick();
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_reg(jdm_pkg::CfgXSel, 0);
    set_reg(jdm_pkg::CfgYSel, 1);
    set_reg(jdm_pkg::CfgInvX, 0);
    set_reg(jdm_pkg::CfgInvY, 0);
    set_reg(jdm_pkg::CfgXGain, 4096);
    set_reg(jdm_pkg::CfgYGain, 4096);
    set_reg(jdm_pkg::CfgRadius, 1638);
    set_reg(jdm_pkg::CfgRange, jdm_pkg::RangeBi10);
    raw_x = 0;
    raw_y = 0;
    filt_x = 0;
    filt_y = 0;
    @(posedge clk);
    test_directed();
    test_random(130, 0, 0);
    test_random(130, 57, 0);
    test_random(130, 0, 57);
    test_random(130, 34, 34);
    test_backpressure();
    test_random(130, 0, 0);
    test_random(130, 57, 57);
    test_random(130, 0, 34);
    test_random(130, 34, 0);
    if (drive_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* joystick_deadzone_mirror_drive_unit.f */
src/jdm_pkg.sv
src/jdm_mul.sv
src/jdm_div.sv
src/joystick_deadzone_mirror_drive_unit.sv
verif/tb.sv
